// ===== rtl/line_editor_with_history_macros.svh =====
// Assertion macros shared by the line editor RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LINE_EDITOR_WITH_HISTORY_MACROS_SVH
`define LINE_EDITOR_WITH_HISTORY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LEW_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LEW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lew_pkg.sv =====
// Shared types and constants of the line editor with history.
// Depends on nothing; used by every RTL module of the block.
package lew_pkg;

    localparam int LINE_MAX_DEF   = 64;
    localparam int HIST_DEPTH_DEF = 16;

    localparam int CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_LINE_CAPACITY = 1'b0;

    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_UP    = 8'h41;
    localparam logic [7:0] CH_DOWN  = 8'h42;

    localparam logic KIND_SUBMIT = 1'b0;
    localparam logic KIND_RECALL = 1'b1;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_DELETE = 3'd1,
        OP_SUBMIT = 3'd2,
        OP_UP     = 3'd3,
        OP_DOWN   = 3'd4
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] ch;
    } cmd_t;

    typedef struct packed {
        logic       line_kind;
        logic [6:0] char_code;
        logic       line_empty;
        logic       saved_to_history;
        logic       last_char;
    } out_item_t;

endpackage

// ===== rtl/lew_fifo.sv =====
// Short command queue between the byte decoder and the line engine.
// Depends on lew_pkg (cmd_t).
module lew_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  lew_pkg::cmd_t push_cmd,
    input  logic          push,
    output logic          full,
    output lew_pkg::cmd_t pop_cmd,
    output logic          pop_valid,
    input  logic          pop
);
    import lew_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_cmd   = mem_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/lew_front.sv =====
// Byte decoder: tracks escape sequences and turns bytes into edit commands.
// Depends on lew_pkg (byte codes, cmd_t).
module lew_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    rx_byte,
    input  logic          in_valid,
    output logic          in_ready,
    output lew_pkg::cmd_t cmd,
    output logic          cmd_push,
    input  logic          q_full
);
    import lew_pkg::*;

    typedef enum logic [2:0] {
        ESC_NONE  = 3'b001,
        ESC_FIRST = 3'b010,
        ESC_SECND = 3'b100
    } esc_t;

    esc_t       esc_reg, esc_next;
    logic [7:0] first_reg, first_next;
    logic       take;

    assign in_ready = !q_full;
    assign take     = in_valid && !q_full;

    always_comb
    begin
        esc_next   = esc_reg;
        first_next = first_reg;
        cmd_push   = 1'b0;
        cmd.op     = OP_APPEND;
        cmd.ch     = rx_byte[6:0];
        if (take)
        begin
            case (esc_reg)
                ESC_FIRST:
                begin
                    first_next = rx_byte;
                    esc_next   = ESC_SECND;
                end
                ESC_SECND:
                begin
                    esc_next = ESC_NONE;
                    if (first_reg == CH_LBRK && rx_byte == CH_UP)
                    begin
                        cmd.op   = OP_UP;
                        cmd_push = 1'b1;
                    end
                    else if (first_reg == CH_LBRK && rx_byte == CH_DOWN)
                    begin
                        cmd.op   = OP_DOWN;
                        cmd_push = 1'b1;
                    end
                end
                default:
                begin
                    if (rx_byte == CH_CR || rx_byte == CH_LF)
                    begin
                        cmd.op   = OP_SUBMIT;
                        cmd_push = 1'b1;
                    end
                    else if (rx_byte == CH_DEL || rx_byte == CH_BS)
                    begin
                        cmd.op   = OP_DELETE;
                        cmd_push = 1'b1;
                    end
                    else if (rx_byte == CH_ESC)
                    begin
                        esc_next = ESC_FIRST;
                    end
                    else if (rx_byte >= CH_SPACE && rx_byte <= CH_TILDE)
                    begin
                        cmd_push = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg   <= ESC_NONE;
            first_reg <= '0;
        end
        else
        begin
            esc_reg   <= esc_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== rtl/lew_back.sv =====
// Line engine: edit line, draft and history memories, recall, store and emit.
// Depends on lew_pkg and line_editor_with_history_macros.svh.
`include "line_editor_with_history_macros.svh"
module lew_back #(
    parameter int LINE_MAX   = lew_pkg::LINE_MAX_DEF,
    parameter int HIST_DEPTH = lew_pkg::HIST_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [lew_pkg::CAP_W-1:0] cap,
    input  lew_pkg::cmd_t             cmd,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    output lew_pkg::out_item_t        out_item,
    output logic                      out_valid,
    input  logic                      out_ready
);
    import lew_pkg::*;

    localparam int LEN_W  = $clog2(LINE_MAX);
    localparam int CNT_W  = $clog2(HIST_DEPTH + 1);
    localparam int SLOT_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SUM_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
    localparam int HADR_W = SLOT_W + LEN_W;
    localparam int HMEM_D = HIST_DEPTH * (2 ** LEN_W);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_SUB_LEN  = 13'b0000000000010,
        S_CMP_RD   = 13'b0000000000100,
        S_CMP_WR   = 13'b0000000001000,
        S_SAVE_RD  = 13'b0000000010000,
        S_SAVE_WR  = 13'b0000000100000,
        S_DRAFT_RD = 13'b0000001000000,
        S_DRAFT_WR = 13'b0000010000000,
        S_LEN_RD   = 13'b0000100000000,
        S_LOAD_RD  = 13'b0001000000000,
        S_LOAD_WR  = 13'b0010000000000,
        S_EMIT_RD  = 13'b0100000000000,
        S_EMIT_WR  = 13'b1000000000000
    } state_t;

    logic [6:0] edit_mem  [LINE_MAX];
    logic [6:0] draft_mem [LINE_MAX];
    logic [6:0] hist_mem  [HMEM_D];
    logic [LEN_W-1:0] hlen_mem [HIST_DEPTH];

    logic [6:0]       edit_q, draft_q, hist_q;
    logic [LEN_W-1:0] hlen_q;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] k_reg, k_next, n_reg, n_next;
    logic [LEN_W-1:0] edit_len_reg, edit_len_next, draft_len_reg, draft_len_next;
    logic [CNT_W-1:0] count_reg, count_next, browse_reg, browse_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next, slot_reg, slot_next;
    logic             saved_reg, saved_next, kind_reg, kind_next;
    logic             src_draft_reg, src_draft_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;

    logic             edit_we, draft_we, hist_we, hlen_we;
    logic [LEN_W-1:0] edit_waddr;
    logic [6:0]       edit_wdata;
    logic [SLOT_W-1:0] store_slot;
    logic [LEN_W-1:0] limit, hlen_cut, draft_cut;
    logic             do_store, go_emit, k_last, out_free, emit_last;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0] age);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(age);
        if (sum >= SUM_W'(HIST_DEPTH))
        begin
            sum = sum - SUM_W'(HIST_DEPTH);
        end
        return SLOT_W'(sum);
    endfunction

    // Clamp capacity into 2..LINE_MAX and keep one less character.
    always_comb
    begin
        if (cap < 7'd2)
        begin
            limit = LEN_W'(1);
        end
        else if (cap > 7'(LINE_MAX))
        begin
            limit = LEN_W'(LINE_MAX - 1);
        end
        else
        begin
            limit = LEN_W'(cap - 7'd1);
        end
    end

    assign hlen_cut   = (hlen_q > limit) ? limit : hlen_q;
    assign draft_cut  = (draft_len_reg > limit) ? limit : draft_len_reg;
    assign store_slot = (count_reg < CNT_W'(HIST_DEPTH)) ? slot_of(oldest_reg, count_reg)
                                                         : oldest_reg;
    assign k_last     = (k_reg == n_reg - 1'b1);
    assign out_free   = !out_valid_reg || out_ready;
    assign emit_last  = (n_reg == '0) || k_last;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        edit_len_next  = edit_len_reg;
        draft_len_next = draft_len_reg;
        count_next     = count_reg;
        browse_next    = browse_reg;
        oldest_next    = oldest_reg;
        slot_next      = slot_reg;
        saved_next     = saved_reg;
        kind_next      = kind_reg;
        src_draft_next = src_draft_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        cmd_ready      = 1'b0;
        edit_we        = 1'b0;
        edit_waddr     = k_reg;
        edit_wdata     = src_draft_reg ? draft_q : hist_q;
        draft_we       = 1'b0;
        hist_we        = 1'b0;
        hlen_we        = 1'b0;
        do_store       = 1'b0;
        go_emit        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_ready = 1'b1;
                    case (cmd.op)
                        OP_APPEND:
                        begin
                            if (edit_len_reg < limit)
                            begin
                                if (browse_reg != count_reg)
                                begin
                                    browse_next    = count_reg;
                                    draft_len_next = '0;
                                end
                                edit_we       = 1'b1;
                                edit_waddr    = edit_len_reg;
                                edit_wdata    = cmd.ch;
                                edit_len_next = edit_len_reg + 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (edit_len_reg != '0)
                            begin
                                edit_len_next = edit_len_reg - 1'b1;
                            end
                        end
                        OP_SUBMIT:
                        begin
                            kind_next = KIND_SUBMIT;
                            if (edit_len_reg == '0)
                            begin
                                saved_next = 1'b0;
                                go_emit    = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                do_store = 1'b1;
                            end
                            else
                            begin
                                slot_next  = slot_of(oldest_reg, count_reg - 1'b1);
                                state_next = S_SUB_LEN;
                            end
                        end
                        OP_UP:
                        begin
                            if (count_reg != '0 && browse_reg != '0)
                            begin
                                browse_next    = browse_reg - 1'b1;
                                slot_next      = slot_of(oldest_reg, browse_reg - 1'b1);
                                src_draft_next = 1'b0;
                                if (browse_reg == count_reg && edit_len_reg != '0)
                                begin
                                    draft_len_next = edit_len_reg;
                                    k_next         = '0;
                                    n_next         = edit_len_reg;
                                    state_next     = S_DRAFT_RD;
                                end
                                else
                                begin
                                    if (browse_reg == count_reg)
                                    begin
                                        draft_len_next = '0;
                                    end
                                    state_next = S_LEN_RD;
                                end
                            end
                        end
                        OP_DOWN:
                        begin
                            if (browse_reg < count_reg)
                            begin
                                browse_next = browse_reg + 1'b1;
                                kind_next   = KIND_RECALL;
                                saved_next  = 1'b0;
                                if (browse_reg + 1'b1 == count_reg)
                                begin
                                    src_draft_next = 1'b1;
                                    edit_len_next  = draft_cut;
                                    if (draft_cut == '0)
                                    begin
                                        go_emit = 1'b1;
                                    end
                                    else
                                    begin
                                        k_next     = '0;
                                        n_next     = draft_cut;
                                        state_next = S_LOAD_RD;
                                    end
                                end
                                else
                                begin
                                    src_draft_next = 1'b0;
                                    slot_next  = slot_of(oldest_reg, browse_reg + 1'b1);
                                    state_next = S_LEN_RD;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SUB_LEN:
            begin
                if (hlen_q != edit_len_reg)
                begin
                    do_store = 1'b1;
                end
                else
                begin
                    k_next     = '0;
                    n_next     = edit_len_reg;
                    state_next = S_CMP_RD;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_WR;
            end
            S_CMP_WR:
            begin
                if (edit_q != hist_q)
                begin
                    do_store = 1'b1;
                end
                else if (k_last)
                begin
                    saved_next = 1'b0;
                    go_emit    = 1'b1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_SAVE_RD:
            begin
                state_next = S_SAVE_WR;
            end
            S_SAVE_WR:
            begin
                hist_we = 1'b1;
                if (k_last)
                begin
                    go_emit = 1'b1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_SAVE_RD;
                end
            end
            S_DRAFT_RD:
            begin
                state_next = S_DRAFT_WR;
            end
            S_DRAFT_WR:
            begin
                draft_we = 1'b1;
                if (k_last)
                begin
                    state_next = S_LEN_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_DRAFT_RD;
                end
            end
            S_LEN_RD:
            begin
                kind_next     = KIND_RECALL;
                saved_next    = 1'b0;
                edit_len_next = hlen_cut;
                if (hlen_cut == '0)
                begin
                    go_emit = 1'b1;
                end
                else
                begin
                    k_next     = '0;
                    n_next     = hlen_cut;
                    state_next = S_LOAD_RD;
                end
            end
            S_LOAD_RD:
            begin
                state_next = S_LOAD_WR;
            end
            S_LOAD_WR:
            begin
                edit_we = 1'b1;
                if (k_last)
                begin
                    go_emit = 1'b1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_LOAD_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                // Hold the character until the output register frees up.
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_item_next.line_kind        = kind_reg;
                    out_item_next.char_code        = (n_reg == '0) ? 7'd0 : edit_q;
                    out_item_next.line_empty       = (n_reg == '0);
                    out_item_next.saved_to_history = saved_reg;
                    out_item_next.last_char        = emit_last;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                        if (kind_reg == KIND_SUBMIT)
                        begin
                            edit_len_next  = '0;
                            draft_len_next = '0;
                            browse_next    = count_reg;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_store)
        begin
            hlen_we    = 1'b1;
            slot_next  = store_slot;
            saved_next = 1'b1;
            k_next     = '0;
            n_next     = edit_len_reg;
            state_next = S_SAVE_RD;
            if (count_reg < CNT_W'(HIST_DEPTH))
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                oldest_next = (oldest_reg == SLOT_W'(HIST_DEPTH - 1)) ? '0
                                                                      : oldest_reg + 1'b1;
            end
        end
        if (go_emit)
        begin
            k_next     = '0;
            n_next     = edit_len_next;
            state_next = S_EMIT_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            n_reg         <= '0;
            edit_len_reg  <= '0;
            draft_len_reg <= '0;
            count_reg     <= '0;
            browse_reg    <= '0;
            oldest_reg    <= '0;
            slot_reg      <= '0;
            saved_reg     <= 1'b0;
            kind_reg      <= KIND_SUBMIT;
            src_draft_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            edit_len_reg  <= edit_len_next;
            draft_len_reg <= draft_len_next;
            count_reg     <= count_next;
            browse_reg    <= browse_next;
            oldest_reg    <= oldest_next;
            slot_reg      <= slot_next;
            saved_reg     <= saved_next;
            kind_reg      <= kind_next;
            src_draft_reg <= src_draft_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // Memories: one write and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (edit_we)
        begin
            edit_mem[edit_waddr] <= edit_wdata;
        end
        edit_q <= edit_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (draft_we)
        begin
            draft_mem[k_reg] <= edit_q;
        end
        draft_q <= draft_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[HADR_W'({slot_reg, k_reg})] <= edit_q;
        end
        hist_q <= hist_mem[HADR_W'({slot_reg, k_reg})];
    end

    always_ff @(posedge clk)
    begin
        if (hlen_we)
        begin
            hlen_mem[store_slot] <= edit_len_reg;
        end
        hlen_q <= hlen_mem[slot_next];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `LEW_ASSERT_IMPLIES(a_browse_in_range, clk, rst_n, 1'b1, browse_reg <= count_reg, "browse past count")
    `LEW_ASSERT_IMPLIES(a_oldest_until_full, clk, rst_n, count_reg < CNT_W'(HIST_DEPTH), oldest_reg == '0, "oldest moved before full")
    `LEW_ASSERT_NEXT(a_last_ends_line, clk, rst_n, state_reg == S_EMIT_WR && out_free && emit_last, state_reg == S_IDLE, "line end without idle")

endmodule

// ===== rtl/line_editor_with_history.sv =====
// Top level of the line editor with history: register port and channel glue.
// Depends on lew_pkg, lew_front, lew_fifo and lew_back.
//
// Usage:
//   Input channel: one terminal byte per word on rx_byte (in_valid/in_ready).
//   Output channel: one word per character of an emitted line (out_valid/
//   out_ready); an empty line is a single word with line_empty set. Every
//   line ends with last_char set. line_kind tells a submitted line from a
//   recalled one that the caller should redraw.
//   Register port: line_capacity at byte address 0, written with the usual
//   setup and access cycles; pready is tied high. Write it only while idle.
// Flow:
//   The decoder takes a byte every cycle into a four-entry command queue
//   while the queue has room. The engine handles appends and deletes in its
//   idle state. A submit may compare with the newest entry, copy into
//   history and emit; a recall may save the draft, load and emit. Each
//   character pass has a read state and a write state because of the
//   registered memory reads of the line, draft and history stores.
// Reset: line, draft and history are empty; capacity returns to 64.
// Stall: a full output register holds the engine, the queue then fills and
//   in_ready drops; nothing is lost.
module line_editor_with_history #(
    parameter int LINE_MAX   = lew_pkg::LINE_MAX_DEF,
    parameter int HIST_DEPTH = lew_pkg::HIST_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lew_pkg::PADDR_W-1:0] paddr,
    input  logic [lew_pkg::PDATA_W-1:0] pwdata,
    output logic [lew_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic [7:0]                  rx_byte,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        line_kind,
    output logic [6:0]                  char_code,
    output logic                        line_empty,
    output logic                        saved_to_history,
    output logic                        last_char,
    output logic                        out_valid,
    input  logic                        out_ready
);
    import lew_pkg::*;

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             wr_hit;
    cmd_t             front_cmd, q_cmd;
    logic             front_push, q_full, q_valid, q_pop;
    out_item_t        item;

    // Register port: one 7-bit register, write on the access phase.
    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_LINE_CAPACITY);
    assign prdata = (paddr[2] == REG_LINE_CAPACITY) ? PDATA_W'(cap_reg) : '0;

    always_comb
    begin
        cap_next = wr_hit ? pwdata[CAP_W-1:0] : cap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // Front: decode bytes and escape sequences into commands.
    lew_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (front_cmd),
        .cmd_push (front_push),
        .q_full   (q_full)
    );

    // Queue: decouple decoding from the multi-cycle line engine.
    lew_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cmd  (front_cmd),
        .push      (front_push),
        .full      (q_full),
        .pop_cmd   (q_cmd),
        .pop_valid (q_valid),
        .pop       (q_pop)
    );

    // Back: edit, recall, store and emit lines.
    lew_back #(
        .LINE_MAX   (LINE_MAX),
        .HIST_DEPTH (HIST_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .cmd       (q_cmd),
        .cmd_valid (q_valid),
        .cmd_ready (q_pop),
        .out_item  (item),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    assign line_kind        = item.line_kind;
    assign char_code        = item.char_code;
    assign line_empty       = item.line_empty;
    assign saved_to_history = item.saved_to_history;
    assign last_char        = item.last_char;

endmodule

// ===== tb/tb_line_editor_with_history.sv =====
// Self-checking testbench for line_editor_with_history: terminal bytes in,
// edited, submitted and recalled lines out. Depends on lew_pkg and the RTL.
module tb_line_editor_with_history;
    timeunit 1ns;
    timeprecision 1ps;

    import lew_pkg::*;

    localparam int LMAX        = 64;
    localparam int HDEPTH      = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 500;    // a submit or recall of a full line plus the queue

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic [7:0]           rx_byte;
    logic                 in_valid;
    logic                 in_ready;
    logic                 line_kind;
    logic [6:0]           char_code;
    logic                 line_empty;
    logic                 saved_to_history;
    logic                 last_char;
    logic                 out_valid;
    logic                 out_ready;

    line_editor_with_history DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .rx_byte          (rx_byte),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .line_kind        (line_kind),
        .char_code        (char_code),
        .line_empty       (line_empty),
        .saved_to_history (saved_to_history),
        .last_char        (last_char),
        .out_valid        (out_valid),
        .out_ready        (out_ready)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Editor model: own copy of the line, draft, history ring and register
    // ------------------------------------------------------------------
    logic [6:0] capacity_reg;
    logic [6:0] line_buf [LMAX];
    int         line_len;
    logic [6:0] draft_buf [LMAX];
    int         draft_len;
    logic [6:0] ring_buf [HDEPTH][LMAX];
    int         ring_len [HDEPTH];
    int         ring_count;
    int         ring_oldest;
    int         browse_pos;
    int         esc_phase;
    logic [7:0] esc_first;

    out_item_t  step_words[$];       // words caused by the byte just modeled
    out_item_t  expected_words[$];   // words still owed by the block

    int         error_count;
    int         cycle_count;
    int         bytes_sent;
    bit         no_idle;             // burst stretches: no gaps, no stalls

    function automatic int keep_limit();
        int cap;
        cap = capacity_reg;
        if (cap < 2) cap = 2;
        if (cap > LMAX) cap = LMAX;
        return cap - 1;
    endfunction

    function automatic int ring_slot(int age);
        return (ring_oldest + age) % HDEPTH;
    endfunction

    // Queue one word per character, or a single empty-line word.
    function automatic void emit_words(logic kind, logic saved);
        out_item_t w;
        if (line_len == 0)
        begin
            w = '{line_kind: kind, char_code: 7'd0, line_empty: 1'b1,
                  saved_to_history: saved, last_char: 1'b1};
            step_words.push_back(w);
            return;
        end
        for (int k = 0; k < line_len; k++)
        begin
            w = '{line_kind: kind, char_code: line_buf[k], line_empty: 1'b0,
                  saved_to_history: saved, last_char: (k + 1 == line_len)};
            step_words.push_back(w);
        end
    endfunction

    // Load a ring entry into the line, cut to the current capacity.
    function automatic void load_from_ring(int slot);
        int n;
        n = ring_len[slot];
        if (n > keep_limit()) n = keep_limit();
        for (int k = 0; k < n; k++) line_buf[k] = ring_buf[slot][k];
        line_len = n;
    endfunction

    function automatic logic commit_to_ring();
        int  slot;
        bit  same;
        if (line_len == 0) return 1'b0;
        if (ring_count > 0)
        begin
            slot = ring_slot(ring_count - 1);
            same = (ring_len[slot] == line_len);
            for (int k = 0; k < line_len && same; k++)
                if (ring_buf[slot][k] != line_buf[k]) same = 0;
            if (same) return 1'b0;
        end
        if (ring_count < HDEPTH)
        begin
            slot = ring_slot(ring_count);
            ring_count++;
        end
        else
        begin
            slot = ring_oldest;
            ring_oldest = (ring_oldest + 1) % HDEPTH;
        end
        for (int k = 0; k < line_len; k++) ring_buf[slot][k] = line_buf[k];
        ring_len[slot] = line_len;
        return 1'b1;
    endfunction

    // Advance the editor model by one received byte.
    function automatic void edit_step(logic [7:0] b);
        logic saved;
        int   n;
        step_words.delete();
        if (esc_phase == 1)
        begin
            esc_first = b;
            esc_phase = 2;
            return;
        end
        if (esc_phase == 2)
        begin
            esc_phase = 0;
            if (esc_first != CH_LBRK) return;
            if (b == CH_UP)
            begin
                if (ring_count == 0 || browse_pos == 0) return;
                if (browse_pos == ring_count)
                begin
                    for (int k = 0; k < line_len; k++) draft_buf[k] = line_buf[k];
                    draft_len = line_len;
                end
                browse_pos--;
                load_from_ring(ring_slot(browse_pos));
                emit_words(KIND_RECALL, 1'b0);
            end
            else if (b == CH_DOWN)
            begin
                if (browse_pos >= ring_count) return;
                browse_pos++;
                if (browse_pos == ring_count)
                begin
                    n = draft_len;
                    if (n > keep_limit()) n = keep_limit();
                    for (int k = 0; k < n; k++) line_buf[k] = draft_buf[k];
                    line_len = n;
                end
                else
                    load_from_ring(ring_slot(browse_pos));
                emit_words(KIND_RECALL, 1'b0);
            end
            return;
        end
        if (b == CH_CR || b == CH_LF)
        begin
            saved = commit_to_ring();
            emit_words(KIND_SUBMIT, saved);
            line_len   = 0;
            draft_len  = 0;
            browse_pos = ring_count;
            return;
        end
        if (b == CH_DEL || b == CH_BS)
        begin
            if (line_len > 0) line_len--;
            return;
        end
        if (b == CH_ESC)
        begin
            esc_phase = 1;
            return;
        end
        if (b < CH_SPACE || b > CH_TILDE) return;
        if (line_len < keep_limit())
        begin
            // typing leaves history browsing
            if (browse_pos != ring_count)
            begin
                browse_pos = ring_count;
                draft_len  = 0;
            end
            line_buf[line_len] = b[6:0];
            line_len++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH t=%0t %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Compare every accepted output word with the oldest one owed.
    always @(posedge clk)
    begin
        out_item_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, char_code", char_code, -1);
            else
            begin
                w = expected_words.pop_front();
                if (line_kind != w.line_kind)
                    report_mismatch("line_kind", line_kind, w.line_kind);
                if (line_empty != w.line_empty)
                    report_mismatch("line_empty", line_empty, w.line_empty);
                if (!w.line_empty && char_code != w.char_code)
                    report_mismatch("char_code", char_code, w.char_code);
                if (saved_to_history != w.saved_to_history)
                    report_mismatch("saved_to_history", saved_to_history,
                                    w.saved_to_history);
                if (last_char != w.last_char)
                    report_mismatch("last_char", last_char, w.last_char);
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_line_editor_with_history: errors");
            $finish;
        end
    end

    // Output side: draw a stall per word, hold ready until the word is taken.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                @(negedge clk) out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Send one byte after a random gap; on acceptance model it.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
        edit_step(b);
    endtask

    task automatic send_and_expect(logic [7:0] b);
        send_byte(b);
        foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endtask

    // Drain, let the engine finish, then write line_capacity (setup + access).
    task automatic write_capacity(logic [PDATA_W-1:0] value);
        @(negedge clk) in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(REG_LINE_CAPACITY);
        pwdata  <= value;
        @(negedge clk) penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity_reg = value[6:0];
    endtask

    task automatic send_escape(logic [7:0] b1, logic [7:0] b2);
        send_and_expect(CH_ESC);
        send_and_expect(b1);
        send_and_expect(b2);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(CH_SPACE, CH_TILDE));
    endfunction

    // Byte the editor must ignore: high half or a stray control code.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ((b >= CH_SPACE && b <= CH_DEL) || b == CH_CR || b == CH_LF ||
            b == CH_BS || b == CH_ESC)
            b = b | 8'h80;
        return b;
    endfunction

    // One random edit action: mostly well-formed typing and history moves.
    task automatic random_action();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 6);
            repeat (n) send_and_expect(printable());
        end
        else if (pick < 55)
            send_and_expect($urandom_range(0, 1) ? CH_CR : CH_LF);
        else if (pick < 70)
            send_escape(CH_LBRK, CH_UP);
        else if (pick < 80)
            send_escape(CH_LBRK, CH_DOWN);
        else if (pick < 87)
            send_and_expect($urandom_range(0, 1) ? CH_DEL : CH_BS);
        else if (pick < 93)
            send_and_expect(noise_byte());
        else if (pick < 97)
            send_escape(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else
        begin
            // recall and resubmit: newest entry must not be duplicated
            send_escape(CH_LBRK, CH_UP);
            send_and_expect(CH_CR);
        end
    endtask

    // Directed opening: typed rows carry their one word, others use the model.
    typedef struct {
        logic [7:0] b;
        bit         typed;
        out_item_t  word;
    } stim_row_t;

    localparam out_item_t EMPTY_SUBMIT = '{line_kind: KIND_SUBMIT, char_code: 7'd0,
        line_empty: 1'b1, saved_to_history: 1'b0, last_char: 1'b1};
    localparam out_item_t NO_WORD = '{default: 1'b0};

    stim_row_t directed_rows [] = '{
        '{CH_CR,    1, EMPTY_SUBMIT},   // empty line on CR
        '{CH_LF,    1, EMPTY_SUBMIT},   // and on LF
        '{CH_ESC,   0, NO_WORD},        // up with empty history
        '{CH_LBRK,  0, NO_WORD},
        '{CH_UP,    0, NO_WORD},
        '{CH_BS,    0, NO_WORD},        // delete on empty line
        '{CH_SPACE, 0, NO_WORD},
        '{CH_TILDE, 0, NO_WORD},
        '{8'h61,    0, NO_WORD},
        '{CH_DEL,   0, NO_WORD},
        '{8'h80,    0, NO_WORD},        // ignored bytes
        '{8'hFF,    0, NO_WORD},
        '{8'h01,    0, NO_WORD},
        '{CH_CR,    0, NO_WORD},        // " ~" stored
        '{CH_ESC,   0, NO_WORD},        // down while not browsing
        '{CH_LBRK,  0, NO_WORD},
        '{CH_DOWN,  0, NO_WORD},
        '{CH_ESC,   0, NO_WORD},        // recall " ~"
        '{CH_LBRK,  0, NO_WORD},
        '{CH_UP,    0, NO_WORD},
        '{CH_ESC,   0, NO_WORD},        // escape swallows CR and LF
        '{CH_CR,    0, NO_WORD},
        '{CH_LF,    0, NO_WORD},
        '{CH_CR,    0, NO_WORD}         // same as newest: not stored again
    };

    // Capacity settings per phase, out-of-range values among them.
    int capacity_plan [] = '{2, 0, 127, 12, 1, 65, 5, 40, 64};

    initial
    begin
        error_count  = 0;
        cycle_count  = 0;
        bytes_sent   = 0;
        no_idle      = 0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rx_byte      = 8'h00;
        in_valid     = 1'b0;
        capacity_reg = CAP_RESET;
        line_len     = 0;
        draft_len    = 0;
        ring_count   = 0;
        ring_oldest  = 0;
        browse_pos   = 0;
        esc_phase    = 0;
        esc_first    = 8'h00;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].typed)
            begin
                send_byte(directed_rows[i].b);
                expected_words.push_back(directed_rows[i].word);
            end
            else
                send_and_expect(directed_rows[i].b);
        end

        // Random phases, each under its own capacity; keep partial lines
        // across writes so a lowered capacity hits a line already held.
        foreach (capacity_plan[p])
        begin
            write_capacity(capacity_plan[p]);
            no_idle = (p % 3 == 2);
            bytes_sent = 0;
            while (bytes_sent < 20) random_action();
        end

        @(negedge clk) in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("tb_line_editor_with_history: clean");
        else
            $display("tb_line_editor_with_history: errors");
        $finish;
    end
endmodule

// ===== line_editor_with_history.f =====
+incdir+rtl
rtl/lew_pkg.sv
rtl/lew_fifo.sv
rtl/lew_front.sv
rtl/lew_back.sv
rtl/line_editor_with_history.sv
tb/tb_line_editor_with_history.sv
